// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the LCD sequencer.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CHK_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lcd_seq_pkg.sv
// Shared types, codes and the cursor row offset table for the LCD sequencer.
// No dependencies.
package lcd_seq_pkg;

    typedef enum logic [2:0] {
        CMD_INSTR   = 3'd0,
        CMD_DATA    = 3'd1,
        CMD_CURSOR  = 3'd2,
        CMD_DISPLAY = 3'd3,
        CMD_SAMPLE  = 3'd4
    } cmd_t;

    localparam logic [7:0] SET_DDRAM_BIT   = 8'h80;
    localparam logic [7:0] DISP_CTRL_BASE  = 8'h08;
    localparam logic [7:0] DISP_CTRL_MASK  = 8'h07;
    localparam logic [2:0] ROW_LIMIT_RESET = 3'd2;

    // One queued burst of pin phases: a single busy-poll read phase, or a
    // full byte write of four phases.
    typedef struct packed {
        logic       wr;
        logic       rs;
        logic [7:0] data_byte;
    } burst_t;

    function automatic logic [7:0] row_offset(input logic [1:0] r);
        logic [7:0] v;
        case (r)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h40;
            2'd2:    v = 8'h10;
            default: v = 8'h50;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/char_lcd_4bit_bus_sequencer_top.sv
// Top level of the 4-bit character LCD bus sequencer.
// Depends on lcd_seq_pkg, lcd_seq_ctrl, lcd_seq_fifo and lcd_seq_out.
//
// Each request item (instruction, data, set cursor, display control) starts a
// busy poll if no transfer is under way; each read sample item answers one
// read phase. An item is taken every cycle while the burst queue has room; it
// is decoded in the cycle after acceptance and yields no phase, one read
// phase, or, when a poll finds the device free, four write phases (high nibble
// E high/low, low nibble E high/low with last set). Phases leave at one per
// cycle while out_ready is high; up to FIFO_DEPTH bursts (a power of two, 2 to
// 16) queue behind the current burst before in_ready drops. The user must
// write row_limit (reset 2) via cfg_we/cfg_wdata only while idle (not enforced).
module char_lcd_4bit_bus_sequencer_top
    import lcd_seq_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] byte_value,
    input  logic [5:0] column,
    input  logic [2:0] row,
    input  logic [3:0] read_nibble,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       reg_select,
    output logic       read_write,
    output logic       enable,
    output logic [3:0] data_nibble,
    output logic       sample_request,
    output logic       last
);

    logic   push;
    burst_t push_burst;
    logic   fifo_full;
    logic   pop;
    logic   not_empty;
    burst_t head;

    lcd_seq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .byte_value  (byte_value),
        .column      (column),
        .row         (row),
        .read_nibble (read_nibble),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_burst  (push_burst)
    );

    lcd_seq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_burst (push_burst),
        .full       (fifo_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    lcd_seq_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .read_write     (read_write),
        .enable         (enable),
        .data_nibble    (data_nibble),
        .sample_request (sample_request),
        .last           (last)
    );

endmodule

// File: hw/rtl/lcd_seq_ctrl.sv
// Request decoder and busy-poll state machine of the LCD sequencer.
// Depends on lcd_seq_pkg; feeds bursts to lcd_seq_fifo.
module lcd_seq_ctrl
    import lcd_seq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] byte_value,
    input  logic [5:0] column,
    input  logic [2:0] row,
    input  logic [3:0] read_nibble,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       fifo_full,
    output logic       push,
    output burst_t     push_burst
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_FIRST,
        PH_WAIT_SECOND
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       busy_seen_reg, busy_seen_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_rs_reg, pend_rs_next;
    logic [2:0] row_limit_reg;

    logic       stg_valid_reg;
    logic [2:0] stg_cmd_reg;
    logic [7:0] stg_byte_reg;
    logic [5:0] stg_col_reg;
    logic [2:0] stg_row_reg;
    logic [3:0] stg_nib_reg;

    logic       has_out;
    logic       advance;
    logic       take;
    logic [1:0] row_eff;
    logic [7:0] req_byte;
    logic       req_rs;

    always_comb
    begin
        row_eff = stg_row_reg[1:0];
        if ((stg_row_reg >= row_limit_reg) || stg_row_reg[2])
        begin
            row_eff = 2'd0;
        end
        req_rs = 1'b0;
        case (stg_cmd_reg)
            CMD_DATA:
            begin
                req_byte = stg_byte_reg;
                req_rs   = 1'b1;
            end
            CMD_CURSOR:  req_byte = SET_DDRAM_BIT | (row_offset(row_eff) + {2'b00, stg_col_reg});
            CMD_DISPLAY: req_byte = DISP_CTRL_BASE | (stg_byte_reg & DISP_CTRL_MASK);
            default:     req_byte = stg_byte_reg;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        busy_seen_next = busy_seen_reg;
        pend_byte_next = pend_byte_reg;
        pend_rs_next   = pend_rs_reg;
        has_out        = 1'b0;
        push_burst     = '{wr: 1'b0, rs: 1'b0, data_byte: pend_byte_reg};
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (stg_cmd_reg <= CMD_DISPLAY)
                begin
                    pend_byte_next = req_byte;
                    pend_rs_next   = req_rs;
                    phase_next     = PH_WAIT_FIRST;
                    has_out        = 1'b1;
                end
            end
            PH_WAIT_FIRST:
            begin
                if (stg_cmd_reg == CMD_SAMPLE)
                begin
                    busy_seen_next = stg_nib_reg[3];
                    phase_next     = PH_WAIT_SECOND;
                    has_out        = 1'b1;
                end
            end
            PH_WAIT_SECOND:
            begin
                if (stg_cmd_reg == CMD_SAMPLE)
                begin
                    has_out = 1'b1;
                    if (busy_seen_reg)
                    begin
                        phase_next = PH_WAIT_FIRST;
                    end
                    else
                    begin
                        push_burst = '{wr: 1'b1, rs: pend_rs_reg, data_byte: pend_byte_reg};
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // An item with no result retires at once; otherwise it waits for queue room.
    assign advance  = stg_valid_reg && (!has_out || !fifo_full);
    assign push     = stg_valid_reg && has_out && !fifo_full;
    assign in_ready = !stg_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            busy_seen_reg <= 1'b0;
            pend_byte_reg <= '0;
            pend_rs_reg   <= 1'b0;
            row_limit_reg <= ROW_LIMIT_RESET;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_limit_reg <= cfg_wdata;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                busy_seen_reg <= busy_seen_next;
                pend_byte_reg <= pend_byte_next;
                pend_rs_reg   <= pend_rs_next;
            end
            stg_valid_reg <= take || (stg_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_cmd_reg  <= command;
            stg_byte_reg <= byte_value;
            stg_col_reg  <= column;
            stg_row_reg  <= row;
            stg_nib_reg  <= read_nibble;
        end
    end

endmodule

// File: hw/rtl/lcd_seq_fifo.sv
// Small queue of pending phase bursts between decoder and output stage.
// Depends on lcd_seq_pkg for the burst type.
module lcd_seq_fifo
    import lcd_seq_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_burst,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output burst_t head
);

    localparam int PW = $clog2(DEPTH);

    burst_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_burst;
        end
    end

endmodule

// File: hw/rtl/lcd_seq_out.sv
// Output stage: expands one queued burst into its pin phases, one per item.
// Depends on lcd_seq_pkg for the burst type.
module lcd_seq_out
    import lcd_seq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       not_empty,
    input  burst_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       reg_select,
    output logic       read_write,
    output logic       enable,
    output logic [3:0] data_nibble,
    output logic       sample_request,
    output logic       last
);

    logic       cur_valid_reg;
    burst_t     cur_reg;
    logic [1:0] step_reg;
    logic       cur_done;

    // A read burst is one phase; a write burst runs steps 0..3.
    assign cur_done = !cur_reg.wr || (step_reg == 2'd3);
    assign pop      = not_empty && (!cur_valid_reg || (out_ready && cur_done));

    assign out_valid      = cur_valid_reg;
    assign reg_select     = cur_reg.wr & cur_reg.rs;
    assign read_write     = !cur_reg.wr;
    assign enable         = !cur_reg.wr || !step_reg[0];
    assign data_nibble    = !cur_reg.wr ? 4'h0 :
                            (step_reg[1] ? cur_reg.data_byte[3:0] : cur_reg.data_byte[7:4]);
    assign sample_request = !cur_reg.wr;
    assign last           = cur_reg.wr && (step_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (cur_valid_reg && out_ready)
            begin
                if (cur_done)
                begin
                    cur_valid_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

endmodule

// File: hw/rtl/lcd_seq_chk.sv
// Port-level checker for the LCD sequencer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lcd_seq_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       reg_select,
    input logic       read_write,
    input logic       enable,
    input logic [3:0] data_nibble,
    input logic       sample_request,
    input logic       last
);

    // A stalled phase must hold until it is taken.
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(data_nibble) && $stable(enable) && $stable(last), "stalled phase changed")

    // Read phases raise E, request a sample, keep RS and last low and drive a zero nibble.
    `CHK_IMPLY(a_read_shape, clk, rst_n, out_valid && read_write, enable && sample_request && !reg_select && (data_nibble == 4'h0) && !last, "malformed read phase")

    // The final phase of a byte is a write with E low.
    `CHK_IMPLY(a_last_shape, clk, rst_n, out_valid && last, !read_write && !enable && !sample_request, "malformed last phase")

endmodule

bind char_lcd_4bit_bus_sequencer_top lcd_seq_chk u_chk (.*);

// File: dv/lcd_seq_pin_checker.sv
`timescale 1ns / 100ps
// Pin phase checker for the 4-bit LCD bus sequencer: watches both channels and
// the row_limit write port, predicts every pin phase and compares. Uses lcd_seq_pkg.
module lcd_seq_pin_checker
    import lcd_seq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] byte_value,
    input  logic [5:0] column,
    input  logic [2:0] row,
    input  logic [3:0] read_nibble,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       reg_select,
    input  logic       read_write,
    input  logic       enable,
    input  logic [3:0] data_nibble,
    input  logic       sample_request,
    input  logic       last,
    output int         fail_count,
    output int         pins_pending,
    output int         pins_checked,
    output int         bytes_done
);

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       e;
        logic [3:0] nib;
        logic       req;
        logic       lst;
    } pin_phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_POLL_FIRST,
        SEQ_POLL_SECOND
    } seq_state_t;

    pin_phase_t exp_pins_q[$];
    seq_state_t seq_state;
    logic [7:0] held_byte;
    logic       held_rs;
    logic       busy_flag;
    logic [2:0] row_limit_q;
    int         mismatches;
    int         checked;
    int         completed;

    task automatic queue_pin(input logic rs, input logic rw, input logic e,
                             input logic [3:0] nib, input logic req, input logic lst);
        pin_phase_t p;
        p.rs  = rs;
        p.rw  = rw;
        p.e   = e;
        p.nib = nib;
        p.req = req;
        p.lst = lst;
        exp_pins_q.push_back(p);
    endtask

    task automatic step_sequencer(input logic [2:0] cmd, input logic [7:0] bv,
                                  input logic [5:0] col, input logic [2:0] rq,
                                  input logic [3:0] nib);
        logic [7:0] next_byte;
        logic       next_rs;
        logic [1:0] r_eff;
        logic [7:0] offs;
        if (cmd <= CMD_DISPLAY) begin
            // A request that arrives while a transfer is under way is dropped.
            if (seq_state == SEQ_IDLE) begin
                next_rs = 1'b0;
                case (cmd)
                    CMD_INSTR:
                        next_byte = bv;
                    CMD_DATA:
                    begin
                        next_byte = bv;
                        next_rs   = 1'b1;
                    end
                    CMD_CURSOR:
                    begin
                        if (rq >= row_limit_q || rq > 3'd3)
                            r_eff = 2'd0;
                        else
                            r_eff = rq[1:0];
                        case (r_eff)
                            2'd0:    offs = 8'h00;
                            2'd1:    offs = 8'h40;
                            2'd2:    offs = 8'h10;
                            default: offs = 8'h50;
                        endcase
                        next_byte = SET_DDRAM_BIT | (offs + {2'b00, col});
                    end
                    default:
                        next_byte = DISP_CTRL_BASE | (bv & DISP_CTRL_MASK);
                endcase
                held_byte = next_byte;
                held_rs   = next_rs;
                seq_state = SEQ_POLL_FIRST;
                queue_pin(1'b0, 1'b1, 1'b1, 4'h0, 1'b1, 1'b0);
            end
        end
        else if (cmd == CMD_SAMPLE) begin
            case (seq_state)
                SEQ_POLL_FIRST:
                begin
                    busy_flag = nib[3];
                    seq_state = SEQ_POLL_SECOND;
                    queue_pin(1'b0, 1'b1, 1'b1, 4'h0, 1'b1, 1'b0);
                end
                SEQ_POLL_SECOND:
                begin
                    if (busy_flag) begin
                        seq_state = SEQ_POLL_FIRST;
                        queue_pin(1'b0, 1'b1, 1'b1, 4'h0, 1'b1, 1'b0);
                    end
                    else begin
                        queue_pin(held_rs, 1'b0, 1'b1, held_byte[7:4], 1'b0, 1'b0);
                        queue_pin(held_rs, 1'b0, 1'b0, held_byte[7:4], 1'b0, 1'b0);
                        queue_pin(held_rs, 1'b0, 1'b1, held_byte[3:0], 1'b0, 1'b0);
                        queue_pin(held_rs, 1'b0, 1'b0, held_byte[3:0], 1'b0, 1'b1);
                        seq_state = SEQ_IDLE;
                    end
                end
                default:
                    ;
            endcase
        end
    endtask

    task automatic report_field(input string name, input logic [3:0] want,
                                input logic [3:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        pin_phase_t want;
        if (!rst_n) begin
            exp_pins_q.delete();
            seq_state   = SEQ_IDLE;
            held_byte   = 8'h00;
            held_rs     = 1'b0;
            busy_flag   = 1'b0;
            row_limit_q = ROW_LIMIT_RESET;
            mismatches  = 0;
            checked     = 0;
            completed   = 0;
        end
        else begin
            if (cfg_we)
                row_limit_q = cfg_wdata;
            if (out_valid && out_ready) begin
                if (exp_pins_q.size() == 0) begin
                    $display("%0t: pin phase with none expected, expected none actual %0h",
                             $time, {reg_select, read_write, enable, data_nibble,
                                     sample_request, last});
                    mismatches++;
                end
                else begin
                    want = exp_pins_q.pop_front();
                    checked++;
                    if (reg_select !== want.rs)
                        report_field("reg_select", {3'b000, want.rs}, {3'b000, reg_select});
                    if (read_write !== want.rw)
                        report_field("read_write", {3'b000, want.rw}, {3'b000, read_write});
                    if (enable !== want.e)
                        report_field("enable", {3'b000, want.e}, {3'b000, enable});
                    if (data_nibble !== want.nib)
                        report_field("data_nibble", want.nib, data_nibble);
                    if (sample_request !== want.req)
                        report_field("sample_request", {3'b000, want.req},
                                     {3'b000, sample_request});
                    if (last !== want.lst)
                        report_field("last", {3'b000, want.lst}, {3'b000, last});
                    if (want.lst)
                        completed++;
                end
            end
            if (in_valid && in_ready)
                step_sequencer(command, byte_value, column, row, read_nibble);
        end
        fail_count   <= mismatches;
        pins_pending <= exp_pins_q.size();
        pins_checked <= checked;
        bytes_done   <= completed;
    end

endmodule

// File: dv/tb_char_lcd_4bit_bus_sequencer_top.sv
`timescale 1ns / 100ps
// Testbench top for the 4-bit LCD bus sequencer: clock, reset, request and
// sample stimulus, output back-pressure and verdict. Uses lcd_seq_pkg and lcd_seq_pin_checker.
module tb_char_lcd_4bit_bus_sequencer_top;
    import lcd_seq_pkg::*;

    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID   = 3'd6;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
    localparam int SETTLE_CYCLES     = 10;
    localparam int HOLD_OFF_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int ITEMS_PER_SEGMENT = 30;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [2:0] command     = 3'd0;
    logic [7:0] byte_value  = 8'h00;
    logic [5:0] column      = 6'd0;
    logic [2:0] row         = 3'd0;
    logic [3:0] read_nibble = 4'h0;
    logic       cfg_we      = 1'b0;
    logic [2:0] cfg_wdata   = 3'd0;
    logic       out_ready   = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [3:0] data_nibble;
    logic       sample_request;
    logic       last;

    int   snd_idle_pct = 21;
    int   rcv_idle_pct = 62;
    logic stall_req    = 1'b0;
    logic stall_done   = 1'b0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;
    int   items_sent   = 0;
    int   useful_items = 0;
    int   row_limits [6] = '{4, 1, 0, 7, 3, 2};
    int   snd_pcts [3]   = '{21, 62, 0};
    int   rcv_pcts [3]   = '{62, 21, 0};

    int fail_count;
    int pins_pending;
    int pins_checked;
    int bytes_done;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    char_lcd_4bit_bus_sequencer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .byte_value     (byte_value),
        .column         (column),
        .row            (row),
        .read_nibble    (read_nibble),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .read_write     (read_write),
        .enable         (enable),
        .data_nibble    (data_nibble),
        .sample_request (sample_request),
        .last           (last)
    );

    lcd_seq_pin_checker u_pin_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .byte_value     (byte_value),
        .column         (column),
        .row            (row),
        .read_nibble    (read_nibble),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .read_write     (read_write),
        .enable         (enable),
        .data_nibble    (data_nibble),
        .sample_request (sample_request),
        .last           (last),
        .fail_count     (fail_count),
        .pins_pending   (pins_pending),
        .pins_checked   (pins_checked),
        .bytes_done     (bytes_done)
    );

    // Receiver: random back-pressure, plus one long hold-off once requested.
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            stall_left <= HOLD_OFF_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Entered and left just after a rising edge; the item is accepted at the
    // edge that ends the task.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] bv,
                             input logic [5:0] col, input logic [2:0] rq,
                             input logic [3:0] nib);
        logic rdy;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        byte_value  <= bv;
        column      <= col;
        row         <= rq;
        read_nibble <= nib;
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
        items_sent++;
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1))
            send_item(3'($urandom_range(CMD_INSTR, CMD_DISPLAY)), 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                      4'($urandom_range(0, 15)));
        else
            send_item(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)),
                      8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    endtask

    // One byte request followed by its busy polls; a few are cut short.
    task automatic random_transfer();
        int busy_polls;
        int n_samples;
        logic [3:0] nib;
        busy_polls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        n_samples  = 2 * (busy_polls + 1);
        if ($urandom_range(0, 99) < 8)
            n_samples = $urandom_range(0, n_samples - 1);
        send_item(3'($urandom_range(CMD_INSTR, CMD_DISPLAY)), 8'($urandom_range(0, 255)),
                  6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15)));
        useful_items++;
        for (int i = 0; i < n_samples; i++) begin
            if ($urandom_range(0, 99) < 8)
                send_noise();
            nib = 4'($urandom_range(0, 15));
            // The first sample of a poll carries busy on every poll but the last.
            if (i % 2 == 0)
                nib[3] = (i < 2 * busy_polls);
            send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      3'($urandom_range(0, 7)), nib);
            useful_items++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pins_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_limit(input logic [2:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Instruction byte of all zeros, device free on the first poll.
        send_item(CMD_INSTR, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'hF);
        // Data byte of all ones with one busy poll before it goes out.
        send_item(CMD_DATA, 8'hFF, 6'd63, 3'd7, 4'hF);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h8);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h7);
        send_item(CMD_SAMPLE, 8'hFF, 6'd63, 3'd7, 4'hF);
        // Cursor on a valid row at the last column, then on a row at the limit.
        send_item(CMD_CURSOR, 8'h00, 6'd63, 3'd1, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_CURSOR, 8'hFF, 6'd63, 3'd2, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_DISPLAY, 8'hFF, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        // A second request during a transfer must be dropped.
        send_item(CMD_INSTR, 8'hA5, 6'd0, 3'd0, 4'h0);
        send_item(CMD_DATA, 8'h5A, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'h0);
        // Stray sample while idle, then the unused command codes.
        send_item(CMD_SAMPLE, 8'h00, 6'd0, 3'd0, 4'hF);
        send_item(CMD_RSVD_FIRST, 8'h00, 6'd0, 3'd0, 4'h0);
        send_item(CMD_RSVD_MID, 8'h3C, 6'd21, 3'd3, 4'h5);
        send_item(CMD_RSVD_LAST, 8'hFF, 6'd63, 3'd7, 4'hF);

        for (int m = 0; m < 3; m++) begin
            for (int s = 0; s < 2; s++) begin
                wait_drained();
                snd_idle_pct = snd_pcts[m];
                rcv_idle_pct <= rcv_pcts[m];
                write_row_limit(3'(row_limits[2 * m + s]));
                if (m == 2 && s == 0)
                    stall_req <= 1'b1;
                target = useful_items + ITEMS_PER_SEGMENT;
                while (useful_items < target) begin
                    if ($urandom_range(0, 99) < 10) begin
                        if ($urandom_range(0, 1))
                            send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)),
                                      6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                                      4'($urandom_range(0, 15)));
                        else
                            send_noise();
                    end
                    random_transfer();
                end
            end
        end

        wait_drained();
        $display("Sent %0d items over three idling modes and six row limits, one long hold-off.",
                 items_sent);
        $display("Checked %0d pin phases, %0d of them closing a byte.", pins_checked, bytes_done);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
